// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: design/fat_pkg.sv
// ---------------------------------------------------------------------------
// fat_pkg
// Types, widths and codes shared by the fit allocator free table.
// ---------------------------------------------------------------------------
package fat_pkg;

    // Field widths fixed by the request and result formats.
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top level parameters.
    localparam int FREE_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF    = 32;

    // Register reset values.
    localparam logic [DATA_W-1:0] HEAP_SIZE_RST = 32'd65536;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_TABLE    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_GROWN    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OOM      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    // Request types.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_GROW,
        ST_RESULT
    } state_t;

    // Flags from the shared subtract and compare unit.
    typedef struct packed {
        logic fits;   // minuend >= subtrahend
        logic less;   // difference < bound
    } fit_flags_t;

endpackage

// File: design/fat_req_if.sv
// ---------------------------------------------------------------------------
// fat_req_if
// Request channel: allocate or release, with valid/ready handshake.
// ---------------------------------------------------------------------------
interface fat_req_if;

    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [fat_pkg::DATA_W-1:0] request_size;
    logic [fat_pkg::DATA_W-1:0] release_addr;

    modport source (
        output valid,
        output req_type,
        output request_size,
        output release_addr,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  request_size,
        input  release_addr,
        output ready
    );

endinterface

// File: design/fat_rsp_if.sv
// ---------------------------------------------------------------------------
// fat_rsp_if
// Result channel: status and granted chunk, with valid/ready handshake.
// ---------------------------------------------------------------------------
interface fat_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [fat_pkg::STATUS_W-1:0] status;
    logic [fat_pkg::DATA_W-1:0]   grant_addr;
    logic [fat_pkg::DATA_W-1:0]   grant_size;

    modport source (
        output valid,
        output status,
        output grant_addr,
        output grant_size,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  grant_addr,
        input  grant_size,
        output ready
    );

endinterface

// File: design/fit_allocator_free_table.sv
// ---------------------------------------------------------------------------
// fit_allocator_free_table
// First fit / best fit allocator over an ordered table of free chunks.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Content
//  req       in         valid/ready          req_type, request_size, release_addr
//  rsp       out        valid/ready          status, grant_addr, grant_size
//  cfg       in         cfg_we (no stall)    cfg_index, cfg_data
//
//  Release: the entry is appended when accepted, unless the table is full, then the result
//  goes to the output register. Allocate: scan, compaction, then the result. A full scan
//  reads every stored entry, and a first fit hit on entry i ends the scan there. Compaction
//  moves the entries behind the grant one place earlier. Growth follows a scan with no fit,
//  or comes straight on an empty table. Scan and compaction issue one table read per cycle.
//  One request is in work at a time; a result waits in the output register until taken.
//  Reset is asynchronous and active low; the table contents need no clearing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fit_allocator_free_table #(
    parameter int FREE_ENTRIES = fat_pkg::FREE_ENTRIES_DEF,
    parameter int ADDR_BITS    = fat_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fat_pkg::DATA_W-1:0]    cfg_data,
    fat_req_if.sink                       req,
    fat_rsp_if.source                     rsp
);

    localparam int DW         = fat_pkg::DATA_W;
    localparam int IDX_W      = $clog2(FREE_ENTRIES);
    localparam int CNT_W      = $clog2(FREE_ENTRIES + 1);
    localparam int ENTRY_W    = 2 * DW;
    localparam int GRANT_BITS = (ADDR_BITS < DW) ? ADDR_BITS : DW;

    // Sequencer and configuration.
    fat_pkg::state_t state_reg, state_next;
    logic            fit_mode_reg;
    logic [DW-1:0]   heap_base_reg;
    logic [DW-1:0]   heap_size_reg;

    // Table bookkeeping.
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DW-1:0]    heap_used_reg, heap_used_next;

    // Request in work.
    logic          op_type_reg;
    logic [DW-1:0] op_size_reg;

    // Read pipeline over the table.
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Chosen entry.
    logic             have_pick_reg, have_pick_next;
    logic [IDX_W-1:0] pick_idx_reg, pick_idx_next;
    logic [DW-1:0]    best_reg, best_next;
    logic [DW-1:0]    pick_size_reg, pick_size_next;
    logic [DW-1:0]    pick_addr_reg, pick_addr_next;

    // Pending result and output register.
    logic [fat_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [DW-1:0]                res_addr_reg, res_addr_next;
    logic [DW-1:0]                res_size_reg, res_size_next;
    logic                         out_vld_reg, out_vld_next;
    logic [fat_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DW-1:0]                out_addr_reg, out_addr_next;
    logic [DW-1:0]                out_size_reg, out_size_next;

    // Table RAM ports.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [DW-1:0]      entry_size;
    logic [DW-1:0]      entry_addr;

    // Shared unit ports.
    logic [DW-1:0]       fu_minuend;
    logic [DW-1:0]       fu_subtrahend;
    logic [DW-1:0]       fu_bound;
    logic [DW-1:0]       fu_surplus;
    fat_pkg::fit_flags_t fu_flags;

    logic                  accept;
    logic                  issue;
    logic                  take;
    logic                  scan_done;
    logic [IDX_W-1:0]      final_pick;
    logic [GRANT_BITS-1:0] heap_addr;

    assign accept     = req.valid && req.ready;
    assign entry_size = ram_rdata[ENTRY_W-1:DW];
    assign entry_addr = ram_rdata[DW-1:0];
    assign heap_addr  = heap_base_reg[GRANT_BITS-1:0] + heap_used_reg[GRANT_BITS-1:0];

    // Ordered table of free chunks: size in the upper half, address in the lower.
    fat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FREE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The shared unit checks table entries during the scan and heap room during growth.
    always_comb
    begin
        if (state_reg == fat_pkg::ST_GROW)
        begin
            fu_minuend    = heap_size_reg;
            fu_subtrahend = heap_used_reg;
            fu_bound      = op_size_reg;
        end
        else
        begin
            fu_minuend    = entry_size;
            fu_subtrahend = op_size_reg;
            fu_bound      = best_reg;
        end
    end

    fat_fit_unit u_fit (
        .minuend    (fu_minuend),
        .subtrahend (fu_subtrahend),
        .bound      (fu_bound),
        .surplus    (fu_surplus),
        .flags      (fu_flags)
    );

    // Scan control: an entry is taken if it fits and is the first one, or, in best fit mode, strictly tighter.
    assign issue      = (issue_idx_reg < count_reg);
    assign take       = rd_vld_reg && fu_flags.fits &&
                        (!have_pick_reg || (fit_mode_reg && fu_flags.less));
    assign scan_done  = (take && !fit_mode_reg) || (!issue && !rd_vld_reg);
    assign final_pick = take ? rd_idx_reg : pick_idx_reg;

    assign req.ready      = (state_reg == fat_pkg::ST_IDLE);
    assign rsp.valid      = out_vld_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.grant_addr = out_addr_reg;
    assign rsp.grant_size = out_size_reg;

    // Next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        heap_used_next  = heap_used_reg;
        issue_idx_next  = issue_idx_reg;
        rd_vld_next     = rd_vld_reg;
        rd_idx_next     = rd_idx_reg;
        have_pick_next  = have_pick_reg;
        pick_idx_next   = pick_idx_reg;
        best_next       = best_reg;
        pick_size_next  = pick_size_reg;
        pick_addr_next  = pick_addr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_size_next   = res_size_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_size_next   = out_size_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            fat_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == fat_pkg::REQ_RELEASE)
                    begin
                        res_addr_next = '0;
                        res_size_next = '0;
                        if (count_reg == CNT_W'(FREE_ENTRIES))
                        begin
                            res_status_next = fat_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = count_reg[IDX_W-1:0];
                            ram_wdata       = {req.request_size, req.release_addr};
                            count_next      = count_reg + 1'b1;
                            res_status_next = fat_pkg::STAT_RELEASED;
                        end
                        state_next = fat_pkg::ST_RESULT;
                    end
                    else
                    begin
                        issue_idx_next = '0;
                        rd_vld_next    = 1'b0;
                        have_pick_next = 1'b0;
                        state_next     = (count_reg == '0) ? fat_pkg::ST_GROW
                                                           : fat_pkg::ST_SCAN;
                    end
                end
            end

            fat_pkg::ST_SCAN:
            begin
                // One read issued per cycle; its data is checked in the following cycle.
                if (issue)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                rd_vld_next = issue;
                rd_idx_next = issue_idx_reg[IDX_W-1:0];
                if (take)
                begin
                    have_pick_next = 1'b1;
                    pick_idx_next  = rd_idx_reg;
                    best_next      = fu_surplus;
                    pick_size_next = entry_size;
                    pick_addr_next = entry_addr;
                end
                if (scan_done)
                begin
                    rd_vld_next = 1'b0;
                    if (take || have_pick_reg)
                    begin
                        issue_idx_next = CNT_W'(final_pick) + 1'b1;
                        state_next     = fat_pkg::ST_COMPACT;
                    end
                    else
                    begin
                        state_next = fat_pkg::ST_GROW;
                    end
                end
            end

            fat_pkg::ST_COMPACT:
            begin
                // Each entry behind the grant is read and written back one place earlier.
                if (issue)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                rd_vld_next = issue;
                rd_idx_next = issue_idx_reg[IDX_W-1:0];
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (!issue && !rd_vld_reg)
                begin
                    count_next      = count_reg - 1'b1;
                    res_status_next = fat_pkg::STAT_TABLE;
                    res_addr_next   = pick_addr_reg;
                    res_size_next   = pick_size_reg;
                    state_next      = fat_pkg::ST_RESULT;
                end
            end

            fat_pkg::ST_GROW:
            begin
                // Room is there when heap_used <= heap_size and the request fits the rest.
                if (fu_flags.fits && !fu_flags.less)
                begin
                    heap_used_next  = heap_used_reg + op_size_reg;
                    res_status_next = fat_pkg::STAT_GROWN;
                    res_addr_next   = DW'(heap_addr);
                    res_size_next   = op_size_reg;
                end
                else
                begin
                    res_status_next = fat_pkg::STAT_OOM;
                    res_addr_next   = '0;
                    res_size_next   = '0;
                end
                state_next = fat_pkg::ST_RESULT;
            end

            fat_pkg::ST_RESULT:
            begin
                // Hand the result over once the output register is free.
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_size_next   = res_size_reg;
                    state_next      = fat_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fat_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fat_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg  <= 1'b0;
            heap_base_reg <= '0;
            heap_size_reg <= fat_pkg::HEAP_SIZE_RST;
            count_reg     <= '0;
            heap_used_reg <= '0;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            have_pick_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fat_pkg::CFG_FIT_MODE:  fit_mode_reg  <= cfg_data[0];
                    fat_pkg::CFG_HEAP_BASE: heap_base_reg <= cfg_data;
                    fat_pkg::CFG_HEAP_SIZE: heap_size_reg <= cfg_data;
                    default:                ;
                endcase
            end
            count_reg     <= count_next;
            heap_used_reg <= heap_used_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= rd_vld_next;
            have_pick_reg <= have_pick_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_type_reg <= req.req_type;
            op_size_reg <= req.request_size;
        end
        rd_idx_reg     <= rd_idx_next;
        pick_idx_reg   <= pick_idx_next;
        best_reg       <= best_next;
        pick_size_reg  <= pick_size_next;
        pick_addr_reg  <= pick_addr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_size_reg   <= res_size_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_size_reg   <= out_size_next;
    end

    // Checks on the sequencer and table bookkeeping.
    `ASSERT_NEVER(a_count_in_range, count_reg > CNT_W'(FREE_ENTRIES), "free count beyond table depth")
    `ASSERT_CLK(a_busy_after_accept, accept |=> state_reg != fat_pkg::ST_IDLE, "idle after a request")
    `ASSERT_CLK(a_grant_shrinks_table, state_reg == fat_pkg::ST_COMPACT && state_next == fat_pkg::ST_RESULT |=> count_reg == CNT_W'($past(count_reg) - 1'b1), "table grant did not shrink the table")
    `ASSERT_CLK(a_release_type_kept, state_reg == fat_pkg::ST_SCAN |-> op_type_reg == fat_pkg::REQ_ALLOC, "table scan for a release request")
    `ASSERT_NEVER(a_write_in_scan, ram_we && state_reg == fat_pkg::ST_SCAN, "table written during the search")

endmodule

// File: design/fat_ram.sv
// ---------------------------------------------------------------------------
// fat_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module fat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fat_fit_unit.sv
// ---------------------------------------------------------------------------
// fat_fit_unit
// Shared subtract and compare unit used for table search and heap checks.
// ---------------------------------------------------------------------------
module fat_fit_unit (
    input  logic [fat_pkg::DATA_W-1:0] minuend,
    input  logic [fat_pkg::DATA_W-1:0] subtrahend,
    input  logic [fat_pkg::DATA_W-1:0] bound,
    output logic [fat_pkg::DATA_W-1:0] surplus,
    output fat_pkg::fit_flags_t        flags
);

    logic [fat_pkg::DATA_W:0] diff;

    // One wide subtract; the borrow tells whether the minuend covers the subtrahend.
    assign diff       = {1'b0, minuend} - {1'b0, subtrahend};
    assign surplus    = diff[fat_pkg::DATA_W-1:0];
    assign flags.fits = ~diff[fat_pkg::DATA_W];

    // The difference is then compared against the running bound.
    assign flags.less = (diff[fat_pkg::DATA_W-1:0] < bound);

endmodule
